/* design/fpfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants for the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int PARTITIONS_DEF = 8;

    localparam int OPC_W   = 2;
    localparam int SLOT_W  = 3;
    localparam int SIZE_W  = 16;
    localparam int FREE_W  = 19;
    localparam int MODE_W  = 2;
    localparam int PIU_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    localparam logic [MODE_W-1:0] FIT_MODE_RST = '0;
    localparam logic [PIU_W-1:0]  PIU_RST      = 4'd8;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD     = 2'd0,
        OP_ALLOC    = 2'd1,
        OP_FREE_ALL = 2'd2,
        OP_NOP      = 2'd3
    } opcode_t;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST  = 2'd0,
        FIT_BEST   = 2'd1,
        FIT_WORST  = 2'd2,
        FIT_UNUSED = 2'd3
    } fit_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_MODE = 2'd0,
        CFG_PIU      = 2'd1,
        CFG_SPARE2   = 2'd2,
        CFG_SPARE3   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_COMMIT = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

/* design/fpfa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_ctrl
// Sequencer: takes one item, walks the partition table, then commits.
// ----------------------------------------------------------------------------
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_COMMIT;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/fpfa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_dp
// Datapath: size memory, mark bits, fit compare, free-size accumulator,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module fpfa_dp
    import fpfa_pkg::*;
#(
    parameter int PARTITIONS = PARTITIONS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [OPC_W-1:0]      in_opcode,
    input  logic [SLOT_W-1:0]     in_slot,
    input  logic [SIZE_W-1:0]     in_request_size,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  out_granted,
    output logic [SLOT_W-1:0]     out_chosen_partition,
    output logic [FREE_W-1:0]     out_free_total
);

    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int PW    = (CNT_W > PIU_W) ? CNT_W : PIU_W;
    localparam int SW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int ACC_W = (SIZE_W + IDX_W > FREE_W) ? SIZE_W + IDX_W : FREE_W;

    // configuration
    logic [MODE_W-1:0] fit_mode_reg;
    logic [PIU_W-1:0]  piu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= FIT_MODE_RST;
            piu_reg      <= PIU_RST;
        end else if (cfg_wr) begin
            case (cfg_index_t'(cfg_index))
                CFG_FIT_MODE: fit_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_PIU:      piu_reg      <= cfg_data[PIU_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] eff_count;
    always_comb begin
        if (PW'(piu_reg) > PW'(PARTITIONS)) begin
            eff_count = CNT_W'(PARTITIONS);
        end else begin
            eff_count = CNT_W'(piu_reg);
        end
    end

    // item registers
    opcode_t           op_reg;
    logic [SIZE_W-1:0] req_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= opcode_t'(in_opcode);
            req_reg <= in_request_size;
        end
    end

    // table storage
    logic [SIZE_W-1:0]     size_mem [PARTITIONS];
    logic [PARTITIONS-1:0] loaded_reg;
    logic [PARTITIONS-1:0] mark_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    assign wr_en   = cmd.capture && (opcode_t'(in_opcode) == OP_LOAD)
                     && (SW'(in_slot) < SW'(PARTITIONS));
    assign wr_addr = IDX_W'(in_slot);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            size_mem[wr_addr] <= in_request_size;
        end
    end

    // scan
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [SIZE_W-1:0] rd_data_reg;
    logic              rd_loaded_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    assign rd_addr = scan_cnt_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            rd_data_reg   <= size_mem[rd_addr];
            rd_loaded_reg <= loaded_reg[rd_addr];
            rd_idx_reg    <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.scan;
            if (cmd.capture) begin
                scan_cnt_reg <= '0;
            end else if (cmd.scan) begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
        end
    end

    // compare stage
    logic [SIZE_W-1:0] cur_size;
    logic [SIZE_W-1:0] cur_left;
    logic              cur_free;
    logic              cur_fits;
    logic              take;

    logic              found_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [SIZE_W-1:0] best_left_reg;
    logic [SIZE_W-1:0] best_size_reg;
    logic [ACC_W-1:0]  acc_reg;

    assign cur_size = rd_loaded_reg ? rd_data_reg : '0;
    assign cur_free = !mark_reg[rd_idx_reg];
    assign cur_fits = cur_free && (cur_size >= req_reg);
    assign cur_left = cur_size - req_reg;

    always_comb begin
        case (fit_mode_t'(fit_mode_reg))
            FIT_BEST:  take = !found_reg || (cur_left < best_left_reg);
            FIT_WORST: take = !found_reg || (cur_left > best_left_reg);
            default:   take = !found_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.capture) begin
            found_reg <= 1'b0;
        end else if (rd_valid_reg && cur_fits) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            acc_reg <= '0;
        end else if (rd_valid_reg) begin
            if (cur_free) begin
                acc_reg <= acc_reg + ACC_W'(cur_size);
            end
            if (cur_fits && take) begin
                best_idx_reg  <= rd_idx_reg;
                best_left_reg <= cur_left;
                best_size_reg <= cur_size;
            end
        end
    end

    // commit
    logic             grant;
    logic [ACC_W-1:0] total;

    assign grant = (op_reg == OP_ALLOC) && found_reg;
    assign total = grant ? (acc_reg - ACC_W'(best_size_reg)) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
            mark_reg   <= '0;
        end else begin
            if (wr_en) begin
                loaded_reg[wr_addr] <= 1'b1;
                mark_reg[wr_addr]   <= 1'b0;
            end
            if (cmd.capture && (opcode_t'(in_opcode) == OP_FREE_ALL)) begin
                mark_reg <= '0;
            end
            if (cmd.commit && grant) begin
                mark_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_granted          <= grant;
            out_chosen_partition <= grant ? SLOT_W'(best_idx_reg) : '0;
            out_free_total       <= (total > ACC_W'(FREE_MAX)) ? FREE_MAX
                                                               : FREE_W'(total);
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign status.out_free  = !m_valid_reg || m_tready;
    assign status.scan_done = (scan_cnt_reg >= eff_count);

endmodule

/* design/fixed_partition_fit_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_unit
// Fixed partition table with first, best and worst fit allocation.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  opcode, slot, request_size
//   m_       out  m_tvalid/m_tready  granted, chosen_partition, free_total
//   cfg_     in   cfg_valid/cfg_ready  register index, write data
//
// Steps per item, N being the number of partitions in use: one table read
// per partition through the single memory read port, one compare of the last
// entry read, one commit.
// One item is worked on at a time; the result register frees the input side
// while a result waits. A stalled result holds the commit step.
// Reset clears marks and valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_unit
    import fpfa_pkg::*;
#(
    parameter int PARTITIONS = PARTITIONS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // opcode[1:0], slot[4:2], request_size[20:5]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // granted[0], chosen_partition[3:1],
                                             // free_total[22:4]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    logic              out_granted;
    logic [SLOT_W-1:0] out_chosen_partition;
    logic [FREE_W-1:0] out_free_total;

    assign cfg_ready = 1'b1;

    fpfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fpfa_dp #(
        .PARTITIONS (PARTITIONS)
    ) u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .in_opcode            (s_tdata[1:0]),
        .in_slot              (s_tdata[4:2]),
        .in_request_size      (s_tdata[20:5]),
        .cfg_wr               (cfg_valid && cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .m_tvalid             (m_tvalid),
        .m_tready             (m_tready),
        .out_granted          (out_granted),
        .out_chosen_partition (out_chosen_partition),
        .out_free_total       (out_free_total)
    );

    assign m_tdata = {1'b0, out_free_total, out_chosen_partition, out_granted};

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in flight");

    a_no_grant_no_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[3:1] == '0))
        else $error("index reported without a grant");
`endif

endmodule
